>>> rtl/cse_pkg.sv
// Shared types and constants for the CAN signal extract/scale block.
// No dependencies; used by cse_extract and can_signal_extract_scale_top.
`timescale 1ns / 1ps

package cse_pkg;

    localparam int DATA_W    = 64;   // payload bits
    localparam int MAX_BYTES = 8;    // payload bytes carried by the port
    localparam int MAX_LEN   = 64;   // longest signal
    localparam int VAL_W     = 48;   // Q32.16 value width
    localparam int SCL_W     = 32;   // Q16.16 scale width

    typedef enum logic [2:0] {
        CFG_START_BIT  = 3'd0,
        CFG_BIT_LENGTH = 3'd1,
        CFG_MOTOROLA   = 3'd2,
        CFG_SIGNED_RAW = 3'd3,
        CFG_SCALE      = 3'd4,
        CFG_OFFSET     = 3'd5,
        CFG_LOWER      = 3'd6,
        CFG_UPPER      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0]              start_bit;
        logic [6:0]              bit_length;
        logic                    motorola_order;
        logic                    signed_raw;
        logic signed [SCL_W-1:0] scale_q16;
        logic signed [VAL_W-1:0] offset_q16;
        logic signed [VAL_W-1:0] lower_limit;
        logic signed [VAL_W-1:0] upper_limit;
    } t_cfg;

    // Gathered raw signal as sign and magnitude, plus in-frame flag
    typedef struct packed {
        logic              vld;
        logic              ok;
        logic              neg;
        logic [DATA_W-1:0] mag;
    } t_gather;

endpackage

>>> rtl/cse_extract.sv
// Bit gathering front end: frame masking, Intel/Motorola extraction, sign handling.
// Three register stages advancing on i_en. Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_extract #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [cse_pkg::DATA_W-1:0]  i_data,
    input  logic [3:0]                  i_nbytes,
    input  cse_pkg::t_cfg               i_cfg,
    output cse_pkg::t_gather            o_gth
);

    localparam logic [3:0] FB = 4'(FRAME_BYTES);
    localparam int DW = cse_pkg::DATA_W;

    logic [3:0]      nb_eff;
    logic [DW-1:0]   data_m;
    logic [DW-1:0]   data_sw;
    logic [5:0]      lin0;
    logic [7:0]      last_sum;
    logic            len_ok;
    logic [DW-1:0]   lenmask;
    logic [2*DW-1:0] shifted;

    logic [2*DW-1:0] n_a_x;
    logic [6:0]      n_a_sh;
    logic            n_a_ok;
    logic [DW-1:0]   n_c_mag;
    logic            n_c_neg;

    // stage A
    logic            r_a_vld;
    logic            r_a_ok;
    logic [2*DW-1:0] r_a_x;
    logic [6:0]      r_a_sh;
    // stage B
    logic            r_b_vld;
    logic            r_b_ok;
    logic [DW-1:0]   r_b_raw;
    // stage C
    logic            r_c_vld;
    logic            r_c_ok;
    logic            r_c_neg;
    logic [DW-1:0]   r_c_mag;

    assign nb_eff = (i_nbytes > FB) ? FB : i_nbytes;

    // zero bytes beyond the frame; byte-swapped copy serves Motorola order
    always_comb begin
        for (int k = 0; k < cse_pkg::MAX_BYTES; k++) begin
            data_m[8*k +: 8] = (4'(k) < nb_eff) ? i_data[8*k +: 8] : 8'h00;
        end
        for (int k = 0; k < cse_pkg::MAX_BYTES; k++) begin
            data_sw[8*(cse_pkg::MAX_BYTES-1-k) +: 8] = data_m[8*k +: 8];
        end
    end

    // Motorola sawtooth is linear in byte*8 + (7 - bit)
    assign lin0   = {i_cfg.start_bit[5:3], ~i_cfg.start_bit[2:0]};
    assign len_ok = (i_cfg.bit_length != 7'd0) && (i_cfg.bit_length <= 7'(cse_pkg::MAX_LEN));

    always_comb begin
        if (i_cfg.motorola_order) begin
            last_sum = {2'b00, lin0} + {1'b0, i_cfg.bit_length} - 8'd1;
            n_a_x    = {data_sw, {DW{1'b0}}};
            n_a_sh   = 7'(8'd128 - {2'b00, lin0} - {1'b0, i_cfg.bit_length});
        end else begin
            last_sum = {2'b00, i_cfg.start_bit} + {1'b0, i_cfg.bit_length} - 8'd1;
            n_a_x    = {{DW{1'b0}}, data_m};
            n_a_sh   = {1'b0, i_cfg.start_bit};
        end
        n_a_ok = len_ok && ({1'b0, last_sum[7:3]} < {2'b00, nb_eff});
    end

    assign lenmask = ~({DW{1'b1}} << i_cfg.bit_length);
    assign shifted = r_a_x >> r_a_sh;

    always_comb begin
        n_c_neg = i_cfg.signed_raw && r_b_raw[6'(i_cfg.bit_length - 7'd1)];
        n_c_mag = n_c_neg ? ((~r_b_raw + 64'd1) & lenmask) : r_b_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ok  <= n_a_ok;
            r_a_x   <= n_a_x;
            r_a_sh  <= n_a_sh;
            r_b_ok  <= r_a_ok;
            r_b_raw <= shifted[DW-1:0] & lenmask;
            r_c_ok  <= r_b_ok;
            r_c_neg <= n_c_neg;
            r_c_mag <= n_c_mag;
        end
    end

    assign o_gth.vld = r_c_vld;
    assign o_gth.ok  = r_c_ok;
    assign o_gth.neg = r_c_neg;
    assign o_gth.mag = r_c_mag;

endmodule

>>> rtl/can_signal_extract_scale_top.sv
// Top level: config registers, gather front end, Q16.16 scaling, offset, clamp, output skid.
// Depends on cse_pkg and cse_extract.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: frame_data[63:0], frame_bytes[67:64]
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: physical_value; tuser: value_valid
//  cfg       in   i_cfg_we (no wait)               i_cfg_idx register, i_cfg_wdata value
//
// One frame per cycle while the skid entry is empty; a result passes the three gather stages,
// multiply, product sum, offset add, and the clamp into the output register.
// Synchronous active-low reset clears valids and loads the register defaults.
// A one-entry skid behind the output register holds the pipeline: o_s_axis_tready
// is the inverted skid valid, so an m_axis stall reaches the input once the skid entry fills.
`timescale 1ns / 1ps

module can_signal_extract_scale_top #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // frame_data[63:0], frame_bytes[67:64], zero fill
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // physical_value[47:0] (signed Q32.16)
    output logic [0:0]  o_m_axis_tuser,   // value_valid[0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_wdata
);

    localparam int VW = cse_pkg::VAL_W;
    localparam int PW = 96;   // product magnitude bits
    localparam int SW = 97;   // signed sum bits

    cse_pkg::t_cfg    r_cfg;
    cse_pkg::t_gather gth;

    logic            en;
    logic [31:0]     smag;
    logic            sneg;
    logic [63:0]     n_d_plo;
    logic [63:0]     n_d_phi;

    logic            r_d_vld;
    logic            r_d_ok;
    logic            r_d_neg;
    logic [63:0]     r_d_plo;
    logic [63:0]     r_d_phi;
    logic            r_e_vld;
    logic            r_e_ok;
    logic            r_e_neg;
    logic [PW-1:0]   r_e_p;
    logic            r_f_vld;
    logic            r_f_ok;
    logic signed [SW-1:0] r_f_v;

    logic signed [SW-1:0] off_w;
    logic signed [SW-1:0] lo_w;
    logic signed [SW-1:0] up_w;
    logic [VW-1:0]   n_val;

    logic            r_out_vld;
    logic [VW-1:0]   r_out_val;
    logic            r_out_ok;
    logic            r_skd_vld;
    logic [VW-1:0]   r_skd_val;
    logic            r_skd_ok;
    logic            push;
    logic            pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_bit      <= 6'd0;
            r_cfg.bit_length     <= 7'd8;
            r_cfg.motorola_order <= 1'b0;
            r_cfg.signed_raw     <= 1'b0;
            r_cfg.scale_q16      <= 32'sh0001_0000;
            r_cfg.offset_q16     <= '0;
            r_cfg.lower_limit    <= {1'b1, {(VW-1){1'b0}}};
            r_cfg.upper_limit    <= {1'b0, {(VW-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (cse_pkg::t_cfg_idx'(i_cfg_idx))
                cse_pkg::CFG_START_BIT:  r_cfg.start_bit      <= i_cfg_wdata[5:0];
                cse_pkg::CFG_BIT_LENGTH: r_cfg.bit_length     <= i_cfg_wdata[6:0];
                cse_pkg::CFG_MOTOROLA:   r_cfg.motorola_order <= i_cfg_wdata[0];
                cse_pkg::CFG_SIGNED_RAW: r_cfg.signed_raw     <= i_cfg_wdata[0];
                cse_pkg::CFG_SCALE:      r_cfg.scale_q16      <= i_cfg_wdata[31:0];
                cse_pkg::CFG_OFFSET:     r_cfg.offset_q16     <= i_cfg_wdata;
                cse_pkg::CFG_LOWER:      r_cfg.lower_limit    <= i_cfg_wdata;
                cse_pkg::CFG_UPPER:      r_cfg.upper_limit    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the skid entry is occupied
    assign en              = !r_skd_vld;
    assign o_s_axis_tready = en;

    cse_extract #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_extract (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata[63:0]),
        .i_nbytes (i_s_axis_tdata[67:64]),
        .i_cfg    (r_cfg),
        .o_gth    (gth)
    );

    // scale as sign and magnitude; 2^31 fits the unsigned magnitude
    assign sneg    = r_cfg.scale_q16[31];
    assign smag    = sneg ? (~r_cfg.scale_q16 + 32'd1) : r_cfg.scale_q16;
    assign n_d_plo = gth.mag[31:0] * smag;
    assign n_d_phi = gth.mag[63:32] * smag;

    assign off_w = SW'(r_cfg.offset_q16);
    assign lo_w  = SW'(r_cfg.lower_limit);
    assign up_w  = SW'(r_cfg.upper_limit);

    // lower clamp first, then upper; upper wins when the limits cross
    always_comb begin
        if (!r_f_ok) begin
            n_val = '0;
        end else if (r_f_v < lo_w) begin
            n_val = (r_cfg.upper_limit < r_cfg.lower_limit) ? r_cfg.upper_limit
                                                            : r_cfg.lower_limit;
        end else if (up_w < r_f_v) begin
            n_val = r_cfg.upper_limit;
        end else begin
            n_val = r_f_v[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= gth.vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ok  <= gth.ok;
            r_d_neg <= gth.neg ^ sneg;
            r_d_plo <= n_d_plo;
            r_d_phi <= n_d_phi;
            r_e_ok  <= r_d_ok;
            r_e_neg <= r_d_neg;
            r_e_p   <= {r_d_phi, 32'd0} + {32'd0, r_d_plo};
            r_f_ok  <= r_e_ok;
            r_f_v   <= r_e_neg ? (off_w - $signed({1'b0, r_e_p}))
                               : (off_w + $signed({1'b0, r_e_p}));
        end
    end

    // output register with one skid entry
    assign push = en && r_f_vld;
    assign pop  = r_out_vld && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (en) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= push;
            end else if (push) begin
                r_skd_vld <= 1'b1;
            end
        end else if (pop) begin
            r_skd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_out_vld || pop) begin
                r_out_val <= n_val;
                r_out_ok  <= r_f_ok;
            end else begin
                r_skd_val <= n_val;
                r_skd_ok  <= r_f_ok;
            end
        end else if (pop) begin
            r_out_val <= r_skd_val;
            r_out_ok  <= r_skd_ok;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_val;
    assign o_m_axis_tuser[0] = r_out_ok;

    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry occupied while output register empty");

    // out-of-frame results carry zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("invalid result with nonzero value");

    // valid result lies within ordered limits
    a_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0] && !(r_cfg.upper_limit < r_cfg.lower_limit))
        |-> (!($signed(o_m_axis_tdata) < r_cfg.lower_limit)
             && !(r_cfg.upper_limit < $signed(o_m_axis_tdata))))
        else $error("result outside clamp limits");

    // a full skid stops intake in the same cycle
    a_stall_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> !o_s_axis_tready)
        else $error("input accepted while skid entry full");

endmodule
